// File: rtl/eulrot_pkg.sv
// Shared types, register indexes and fixed-point helpers for the XYZ point rotation core.
package eulrot_pkg;

    localparam int CoordW = 32;
    localparam int CoefW  = 16;
    localparam int FracW  = 14;
    localparam int ProdW  = CoordW + CoefW;
    localparam int TermW  = ProdW - FracW;
    localparam int SumW   = TermW + 1;
    localparam int IdxW   = 3;

    localparam logic [IdxW-1:0] REG_COS_X = 3'd0;
    localparam logic [IdxW-1:0] REG_SIN_X = 3'd1;
    localparam logic [IdxW-1:0] REG_COS_Y = 3'd2;
    localparam logic [IdxW-1:0] REG_SIN_Y = 3'd3;
    localparam logic [IdxW-1:0] REG_COS_Z = 3'd4;
    localparam logic [IdxW-1:0] REG_SIN_Z = 3'd5;

    localparam logic signed [CoefW-1:0] COEF_ONE  = 16'sd16384;
    localparam logic signed [CoefW-1:0] COEF_ZERO = 16'sd0;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [CoefW-1:0]  coef_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [TermW-1:0]  term_t;
    typedef logic signed [SumW-1:0]   sum_t;

    typedef struct packed {
        coord_t x_in;
        coord_t y_in;
        coord_t z_in;
    } point_in_t;

    typedef struct packed {
        coord_t x_out;
        coord_t y_out;
        coord_t z_out;
    } point_out_t;

    // Exact signed product, coordinate times coefficient.
    function automatic prod_t mul(input coord_t a, input coef_t b);
        prod_t pa;
        prod_t pb;
        pa = prod_t'(a);
        pb = prod_t'(b);
        return pa * pb;
    endfunction

    // Floor of p / 2^FracW: arithmetic shift drops the fraction.
    function automatic term_t floor_term(input prod_t p);
        return p[ProdW-1:FracW];
    endfunction

    // Sum of two floored terms, clamped to the coordinate range.
    function automatic coord_t sum_sat(input prod_t a, input prod_t b);
        sum_t s;
        s = sum_t'(floor_term(a)) + sum_t'(floor_term(b));
        if (s > sum_t'(coord_t'({1'b0, {(CoordW-1){1'b1}}}))) begin
            return {1'b0, {(CoordW-1){1'b1}}};
        end else if (s < sum_t'(coord_t'({1'b1, {(CoordW-1){1'b0}}}))) begin
            return {1'b1, {(CoordW-1){1'b0}}};
        end
        return s[CoordW-1:0];
    endfunction

endpackage

// File: rtl/euler_xyz_point_rotation_core.sv
// Top level: six-stage pipelined Euler XYZ rotation of Q16.16 points by Q2.14 coefficients.
//
//  channel  | handshake            | payload                        | direction
//  ---------+----------------------+--------------------------------+----------
//  s_       | s_valid / s_ready    | s_data  (x_in, y_in, z_in)     | in
//  m_       | m_valid / m_ready    | m_data  (x_out, y_out, z_out)  | out
//  cfg_     | cfg_valid / cfg_ready| cfg_index (3b), cfg_data (16b) | in
//
// One point per cycle sustained while m_ready holds; six register stages, the first
// loaded at the input transfer edge and the last driving the m_ port.
// Each rotation takes two stages: four 32x16 products, then two floored sums
// with saturation.
// aresetn (synchronous, active low) empties the pipe and loads the identity
// rotation (cos 1.0, sin 0.0). A stall holds every occupied stage with no empty
// stage after it; an empty stage keeps taking data, so bubbles close up behind a stalled output.
module euler_xyz_point_rotation_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  eulrot_pkg::point_in_t    s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output eulrot_pkg::point_out_t   m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [15:0]              cfg_data
);
    import eulrot_pkg::*;

    localparam int NStages = 6;

    // Coefficient registers
    coef_t cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg, cos_z_reg, sin_z_reg;

    // Config writes are always taken; indexes above five are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_x_reg <= COEF_ONE;
            sin_x_reg <= COEF_ZERO;
            cos_y_reg <= COEF_ONE;
            sin_y_reg <= COEF_ZERO;
            cos_z_reg <= COEF_ONE;
            sin_z_reg <= COEF_ZERO;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COS_X: cos_x_reg <= cfg_data;
                REG_SIN_X: sin_x_reg <= cfg_data;
                REG_COS_Y: cos_y_reg <= cfg_data;
                REG_SIN_Y: sin_y_reg <= cfg_data;
                REG_COS_Z: cos_z_reg <= cfg_data;
                REG_SIN_Z: sin_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valids and per-stage advance. A stage loads when it is empty or
    // its contents move on in the same cycle.
    logic [NStages-1:0] valid_reg;
    logic [NStages-1:0] adv;

    always_comb begin
        adv[NStages-1] = !valid_reg[NStages-1] || m_ready;
        for (int i = NStages - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NStages; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 0: products for the X rotation (acts on y, z). Negated terms
    // carry their sign into the product so the floor rounds the same way.
    prod_t  s0_ycx_reg, s0_nzsx_reg, s0_ysx_reg, s0_zcx_reg;
    coord_t s0_x_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s0_ycx_reg  <= mul(s_data.y_in, cos_x_reg);
            s0_nzsx_reg <= -mul(s_data.z_in, sin_x_reg);
            s0_ysx_reg  <= mul(s_data.y_in, sin_x_reg);
            s0_zcx_reg  <= mul(s_data.z_in, cos_x_reg);
            s0_x_reg    <= s_data.x_in;
        end
    end

    // Stage 1: y1, z1
    coord_t s1_x_reg, s1_y1_reg, s1_z1_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_y1_reg <= sum_sat(s0_ycx_reg, s0_nzsx_reg);
            s1_z1_reg <= sum_sat(s0_ysx_reg, s0_zcx_reg);
            s1_x_reg  <= s0_x_reg;
        end
    end

    // Stage 2: products for the Y rotation (acts on x, z1)
    prod_t  s2_xcy_reg, s2_z1sy_reg, s2_nxsy_reg, s2_z1cy_reg;
    coord_t s2_y1_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s2_xcy_reg  <= mul(s1_x_reg, cos_y_reg);
            s2_z1sy_reg <= mul(s1_z1_reg, sin_y_reg);
            s2_nxsy_reg <= -mul(s1_x_reg, sin_y_reg);
            s2_z1cy_reg <= mul(s1_z1_reg, cos_y_reg);
            s2_y1_reg   <= s1_y1_reg;
        end
    end

    // Stage 3: x1, z2
    coord_t s3_x1_reg, s3_y1_reg, s3_z2_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_x1_reg <= sum_sat(s2_xcy_reg, s2_z1sy_reg);
            s3_z2_reg <= sum_sat(s2_nxsy_reg, s2_z1cy_reg);
            s3_y1_reg <= s2_y1_reg;
        end
    end

    // Stage 4: products for the Z rotation (acts on x1, y1)
    prod_t  s4_x1cz_reg, s4_ny1sz_reg, s4_x1sz_reg, s4_y1cz_reg;
    coord_t s4_z2_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s4_x1cz_reg  <= mul(s3_x1_reg, cos_z_reg);
            s4_ny1sz_reg <= -mul(s3_y1_reg, sin_z_reg);
            s4_x1sz_reg  <= mul(s3_x1_reg, sin_z_reg);
            s4_y1cz_reg  <= mul(s3_y1_reg, cos_z_reg);
            s4_z2_reg    <= s3_z2_reg;
        end
    end

    // Stage 5: x2, y2 -- this is the output register
    point_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            out_reg.x_out <= sum_sat(s4_x1cz_reg, s4_ny1sz_reg);
            out_reg.y_out <= sum_sat(s4_x1sz_reg, s4_y1cz_reg);
            out_reg.z_out <= s4_z2_reg;
        end
    end

    assign m_valid = valid_reg[NStages-1];
    assign m_data  = out_reg;

    // A transfer at the input lands in the first stage.
    a_in_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted point did not enter stage 0");

    // With the sink ready, the whole pipe moves, so the input must be open.
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output drains");

    // A full pipe with a stalled output must refuse new points.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (($countones(valid_reg) == NStages) && !m_ready) |-> !s_ready)
        else $error("input open while pipe is full and stalled");

    // Occupancy cannot grow while the input is idle.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_valid && !m_valid) |=> ($countones(valid_reg) <= $countones($past(valid_reg))))
        else $error("pipe occupancy grew without an input transfer");

endmodule

// File: test/euler_xyz_point_rotation_core_tb.sv
// Self-checking testbench for the Euler XYZ point rotation core: predicted points vs. the m_ port.
package eulrot_check_pkg;
    import eulrot_pkg::*;

    localparam coord_t          COORD_MAX    = 32'sh7fff_ffff;
    localparam coord_t          COORD_MIN    = 32'sh8000_0000;
    // indexes past the last coefficient; writes there must change nothing
    localparam logic [IdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IdxW-1:0] REG_SPARE_HI = 3'd7;

    class rotation_scoreboard;
        coef_t      coef_bank[6];
        point_out_t expected_points[$];
        int         errors;

        function new();
            coef_bank[REG_COS_X] = COEF_ONE;
            coef_bank[REG_SIN_X] = COEF_ZERO;
            coef_bank[REG_COS_Y] = COEF_ONE;
            coef_bank[REG_SIN_Y] = COEF_ZERO;
            coef_bank[REG_COS_Z] = COEF_ONE;
            coef_bank[REG_SIN_Z] = COEF_ZERO;
            errors  = 0;
        endfunction

        function void load_coef(logic [IdxW-1:0] idx, coef_t value);
            if (idx <= REG_SIN_Z) begin
                coef_bank[idx] = value;
            end
        endfunction

        // arithmetic shift of a signed product is the floor of p / 2^14
        static function longint floor_q14(longint p);
            return p >>> FracW;
        endfunction

        static function coord_t clamp_coord(longint s);
            if (s > longint'(COORD_MAX)) begin
                return COORD_MAX;
            end else if (s < longint'(COORD_MIN)) begin
                return COORD_MIN;
            end
            return coord_t'(s);
        endfunction

        // X, then Y, then Z; each stage takes the clamped results of the one before
        function point_out_t rotate_point(point_in_t p);
            longint     x, y, z;
            longint     cx, sx, cy, sy, cz, sz;
            coord_t     y1, z1, x1;
            point_out_t r;
            x  = $signed(p.x_in);
            y  = $signed(p.y_in);
            z  = $signed(p.z_in);
            cx = coef_bank[REG_COS_X];
            sx = coef_bank[REG_SIN_X];
            cy = coef_bank[REG_COS_Y];
            sy = coef_bank[REG_SIN_Y];
            cz = coef_bank[REG_COS_Z];
            sz = coef_bank[REG_SIN_Z];
            y1 = clamp_coord(floor_q14(y * cx) + floor_q14(-(z * sx)));
            z1 = clamp_coord(floor_q14(y * sx) + floor_q14(z * cx));
            x1 = clamp_coord(floor_q14(x * cy) + floor_q14(longint'(z1) * sy));
            r.z_out = clamp_coord(floor_q14(-(x * sy)) + floor_q14(longint'(z1) * cy));
            r.x_out = clamp_coord(floor_q14(longint'(x1) * cz)
                                  + floor_q14(-(longint'(y1) * sz)));
            r.y_out = clamp_coord(floor_q14(longint'(x1) * sz) + floor_q14(longint'(y1) * cz));
            return r;
        endfunction

        function void note_point(point_in_t p);
            expected_points.insert(expected_points.size(), rotate_point(p));
        endfunction

        function void compare_field(string name, coord_t want, coord_t got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_point(point_out_t got);
            point_out_t want;
            if (expected_points.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, expected none got %h", $time, got);
                return;
            end
            want = expected_points.pop_front();
            compare_field("x_out", want.x_out, got.x_out);
            compare_field("y_out", want.y_out, got.y_out);
            compare_field("z_out", want.z_out, got.z_out);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass
endpackage

module euler_xyz_point_rotation_core_tb;
    import eulrot_pkg::*;
    import eulrot_check_pkg::*;

    localparam int ClockPeriod    = 20;
    localparam int RunLimitCycles = 200_000;
    localparam int IdlePercent    = 35;
    localparam int RandomPhases   = 8;
    localparam int PhaseItems     = 128;
    localparam int HoldCycles     = 150;
    // pipe is six deep; give it a little more before touching registers or ending
    localparam int SettleCycles   = 12;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    point_in_t        s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    point_out_t       m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IdxW-1:0]  cfg_index = '0;
    logic [CoefW-1:0] cfg_data  = '0;

    // quiet: neither side idles; hold_req: ask the result sink for a long stall
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    rotation_scoreboard board;

    always #(ClockPeriod / 2) aclk = ~aclk;

    euler_xyz_point_rotation_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Result sink. Ready changes on the falling edge only. A hold request
    // drops ready for a long stall, counted down here from HoldCycles, so the
    // sender keeps pushing into a full pipe and sees s_ready go low.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HoldCycles;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IdlePercent);
            end
        end
    end

    // Every output transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_point(m_data);
        end
    end

    // Offers one point; unless quiet, each cycle before it idles at random.
    // Valid stays high after the transfer, so back-to-back points never
    // drop it; whoever stops sending must lower it (see drain).
    task automatic send_point(input point_in_t p);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < IdlePercent) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        board.note_point(p);
    endtask

    // Register writes happen only with the pipe empty; the predictor picks the
    // value up at the transfer edge.
    task automatic write_coef(input logic [IdxW-1:0] idx, input coef_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.load_coef(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait for every predicted point to come out.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        drain();
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // Range ends, mixed signs, and small odd values where a negated product
    // floors differently from a truncated one.
    task automatic send_corner_points();
        point_in_t corners[8];
        corners = '{
            '{0, 0, 0},
            '{COORD_MAX, COORD_MAX, COORD_MAX},
            '{COORD_MIN, COORD_MIN, COORD_MIN},
            '{COORD_MIN, COORD_MAX, COORD_MIN},
            '{COORD_MAX, COORD_MIN, COORD_MAX},
            '{-1, -1, -1},
            '{1, -1, 3},
            '{-12345, 98765, -7}
        };
        foreach (corners[k]) begin
            send_point(corners[k]);
        end
    endtask

    // About as many full-range words as small coordinates, so results do not
    // always clamp, and now and then a range end.
    function automatic coord_t random_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(4))
                0: return COORD_MAX;
                1: return COORD_MIN;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        if (pick < 55) begin
            return coord_t'($urandom);
        end
        return coord_t'(int'($urandom_range(2 ** 21)) - 2 ** 20);
    endfunction

    // Proper sines and cosines most of the time; any 16-bit word otherwise,
    // since values past +-1.0 are legal and only push the stages to clamp.
    function automatic coef_t random_coef();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(2))
                0: return COEF_ONE;
                1: return -COEF_ONE;
                default: return COEF_ZERO;
            endcase
        end
        if (pick < 40) begin
            return coef_t'($urandom);
        end
        return coef_t'(int'($urandom_range(32768)) - 16384);
    endfunction

    initial begin : stimulus
        point_in_t p;
        board = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // identity rotation straight out of reset
        send_corner_points();
        settle();

        // coefficients at and past +-1.0 with full-scale inputs, so range-end points clamp;
        // writes to the spare indexes must leave the bank alone
        write_coef(REG_COS_X, 16'sh8000);
        write_coef(REG_SIN_X, 16'sh7fff);
        write_coef(REG_COS_Y, -COEF_ONE);
        write_coef(REG_SIN_Y, COEF_ONE);
        write_coef(REG_COS_Z, 16'sd12345);
        write_coef(REG_SIN_Z, -16'sd1);
        write_coef(REG_SPARE_LO, 16'sh5a5a);
        write_coef(REG_SPARE_HI, 16'sha5a5);
        send_corner_points();
        settle();

        // 45 degrees on every axis with mixed signs: inexact products, so the
        // floor of each subtracted term shows
        write_coef(REG_COS_X, 16'sd11585);
        write_coef(REG_SIN_X, 16'sd11585);
        write_coef(REG_COS_Y, 16'sd11585);
        write_coef(REG_SIN_Y, -16'sd11585);
        write_coef(REG_COS_Z, -16'sd11585);
        write_coef(REG_SIN_Z, 16'sd11585);
        send_corner_points();

        // Random phases: new angles each time. Phase 2 runs with no idling at
        // all, phase 4 starts with a long sink stall, phase 6 pauses mid-way
        // until the pipe is empty.
        for (int phase = 0; phase < RandomPhases; phase++) begin
            settle();
            for (int r = 0; r <= REG_SIN_Z; r++) begin
                write_coef(r[IdxW-1:0], random_coef());
            end
            if ($urandom_range(3) == 0) begin
                write_coef($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, coef_t'($urandom));
            end
            quiet = (phase == 2);
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                if (phase == 6 && n == PhaseItems / 2) begin
                    drain();
                end
                p.x_in = random_coord();
                p.y_in = random_coord();
                p.z_in = random_coord();
                send_point(p);
            end
        end

        quiet = 1'b0;
        drain();
        // anything that still shows up now is an extra result
        repeat (SettleCycles) @(posedge aclk);
        if (board.errors == 0) begin
            $display("euler_xyz_point_rotation_core verification clean");
        end else begin
            $display("euler_xyz_point_rotation_core verification failed");
        end
        $finish;
    end

    // Far beyond the slowest legal run: ~1050 points with gaps and stalls on
    // both sides, two long pauses and all register writes.
    initial begin : watchdog
        #(RunLimitCycles * ClockPeriod);
        $display("euler_xyz_point_rotation_core verification failed");
        $finish;
    end

endmodule

// File: euler_xyz_point_rotation_core.f
rtl/eulrot_pkg.sv
rtl/euler_xyz_point_rotation_core.sv
test/euler_xyz_point_rotation_core_tb.sv
